/* rtl/contact_point_from_closest_pair_core_defines.svh */
// Assertion macros for the contact point core.
`ifndef CONTACT_POINT_FROM_CLOSEST_PAIR_CORE_DEFINES_SVH
`define CONTACT_POINT_FROM_CLOSEST_PAIR_CORE_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define CP_ASSERT_IMP(label, clk, rst_n, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
    else $error("cp assertion failed");
// Next-cycle implication.
`define CP_ASSERT_NEXT(label, clk, rst_n, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
    else $error("cp assertion failed");
`endif

/* rtl/cpcp_pkg.sv */
// Package: payload types and constants of the contact point core.
`default_nettype none
package cpcp_pkg;
  localparam int unsigned FracBits = 16;
  localparam int unsigned UnitOne = 16384;
  localparam int unsigned RootBits = 33;
  localparam int unsigned QuoBits = 16;

  typedef struct packed {
    logic signed [31:0] pa_x;
    logic signed [31:0] pa_y;
    logic signed [31:0] pa_z;
    logic signed [31:0] qb_x;
    logic signed [31:0] qb_y;
    logic signed [31:0] qb_z;
    logic               is_outside;
    logic [30:0]        margin_a;
    logic [30:0]        margin_b;
    logic signed [31:0] particle_a;
    logic signed [31:0] particle_b;
    logic               friction_in;
  } cp_in_t;

  typedef struct packed {
    logic signed [31:0] mid_x;
    logic signed [31:0] mid_y;
    logic signed [31:0] mid_z;
    logic signed [15:0] unit_x;
    logic signed [15:0] unit_y;
    logic signed [15:0] unit_z;
    logic signed [35:0] signed_gap;
    logic signed [35:0] penetration;
    logic signed [31:0] index_a_out;
    logic signed [31:0] index_b_out;
    logic               friction_out;
    logic               degenerate;
  } cp_out_t;

  // Data carried alongside the root and division stages.
  typedef struct packed {
    logic signed [31:0] mid_x;
    logic signed [31:0] mid_y;
    logic signed [31:0] mid_z;
    logic [2:0]         neg;
    logic [32:0]        ax;
    logic [32:0]        ay;
    logic [32:0]        az;
    logic               is_outside;
    logic [31:0]        msum;
    logic signed [31:0] particle_a;
    logic signed [31:0] particle_b;
    logic               friction_in;
  } cp_side_t;
endpackage
`default_nettype wire

/* rtl/cpcp_sqrt_pipe.sv */
// Pipelined square root, one result bit per stage, with side data.
`default_nettype none
module cpcp_sqrt_pipe (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                valid_i,
  input  wire logic [65:0]         rad_i,
  input  wire cpcp_pkg::cp_side_t  side_i,
  output logic                     valid_o,
  output logic [32:0]              root_o,
  output cpcp_pkg::cp_side_t       side_o
);
  import cpcp_pkg::*;
  localparam int unsigned N = RootBits;

  logic [N:1]       vld_q;
  logic [65:0]      rad_q  [N+1];
  logic [34:0]      rem_q  [N+1];
  logic [32:0]      root_q [N+1];
  cp_side_t         side_q [N+1];

  always_comb begin
    rad_q[0]  = rad_i;
    rem_q[0]  = '0;
    root_q[0] = '0;
    side_q[0] = side_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[N-1:1], valid_i};
    end
  end

  for (genvar s = 0; s < N; s++) begin : g_stage
    logic [34:0] rem_d, trial;
    logic [32:0] root_d;
    always_comb begin
      rem_d  = {rem_q[s][32:0], rad_q[s][65:64]};
      trial  = {root_q[s], 2'b01};
      if (rem_d >= trial) begin
        rem_d  = rem_d - trial;
        root_d = {root_q[s][31:0], 1'b1};
      end else begin
        root_d = {root_q[s][31:0], 1'b0};
      end
    end
    always_ff @(posedge clk_i) begin
      rad_q[s+1]  <= {rad_q[s][63:0], 2'b00};
      rem_q[s+1]  <= rem_d;
      root_q[s+1] <= root_d;
      side_q[s+1] <= side_q[s];
    end
  end

  assign valid_o = vld_q[N];
  assign root_o  = root_q[N];
  assign side_o  = side_q[N];
endmodule
`default_nettype wire

/* rtl/contact_point_from_closest_pair_core.sv */
// Top level of the contact point core: midpoint, normal, gap and depth.
//
// Usage: drive a beat on in_i with start high; busy is always low, so a
// beat is taken on every cycle that start is high. Each beat yields one
// result beat on out_o, marked by done_o for exactly one cycle.
// Pipeline: 2 input stages (squares, then their sum), 33 square-root stages
// (one root bit per stage), 16 division stages (one quotient bit per stage)
// and 1 output register that drives done_o and out_o.
// Throughput is one beat per cycle; the root and division pipelines set the
// depth.
// Coincident points give the degenerate flag set, a zero normal and zero gap.
// Reset clears every valid bit; beats in flight are dropped. The receiver
// cannot stall, so results leave in order without any holding.
`default_nettype none
module contact_point_from_closest_pair_core (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start,
  output logic                   busy,
  input  wire cpcp_pkg::cp_in_t  in_i,
  output logic                   done_o,
  output cpcp_pkg::cp_out_t      out_o
);
  import cpcp_pkg::*;
`include "contact_point_from_closest_pair_core_defines.svh"

  localparam int unsigned Q = QuoBits;

  assign busy = 1'b0;
  logic acc;
  assign acc = start && !busy;

  // Stage 0: differences, midpoints and absolute differences; the squares and their sum follow.
  logic signed [32:0] dx, dy, dz, sx, sy, sz;
  logic [32:0] ax, ay, az;
  cp_side_t side0_d, side0_q;
  logic [65:0] rad_q;
  logic [65:0] sqx_q, sqy_q, sqz_q;
  logic v0_q, v1_q;
  cp_side_t side1_q;

  always_comb begin
    dx = 33'(in_i.pa_x) - 33'(in_i.qb_x);
    dy = 33'(in_i.pa_y) - 33'(in_i.qb_y);
    dz = 33'(in_i.pa_z) - 33'(in_i.qb_z);
    sx = 33'(in_i.pa_x) + 33'(in_i.qb_x);
    sy = 33'(in_i.pa_y) + 33'(in_i.qb_y);
    sz = 33'(in_i.pa_z) + 33'(in_i.qb_z);
    ax = dx[32] ? 33'(-dx) : 33'(dx);
    ay = dy[32] ? 33'(-dy) : 33'(dy);
    az = dz[32] ? 33'(-dz) : 33'(dz);
    side0_d.mid_x = sx[32:1];
    side0_d.mid_y = sy[32:1];
    side0_d.mid_z = sz[32:1];
    side0_d.neg = {dx[32], dy[32], dz[32]};
    side0_d.ax = ax;
    side0_d.ay = ay;
    side0_d.az = az;
    side0_d.is_outside = in_i.is_outside;
    side0_d.msum = 32'(in_i.margin_a) + 32'(in_i.margin_b);
    side0_d.particle_a = in_i.particle_a;
    side0_d.particle_b = in_i.particle_b;
    side0_d.friction_in = in_i.friction_in;
  end

  // Squares registered, then summed; each square is a 33x33 product.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
    end else begin
      v0_q <= acc;
      v1_q <= v0_q;
    end
  end
  always_ff @(posedge clk_i) begin
    side0_q <= side0_d;
    sqx_q   <= 66'(ax) * 66'(ax);
    sqy_q   <= 66'(ay) * 66'(ay);
    sqz_q   <= 66'(az) * 66'(az);
    side1_q <= side0_q;
    rad_q   <= sqx_q + sqy_q + sqz_q;
  end

  logic        vr;
  logic [32:0] root;
  cp_side_t    sider;
  cpcp_sqrt_pipe u_sqrt (
    .clk_i, .rst_ni,
    .valid_i (v1_q),
    .rad_i   (rad_q),
    .side_i  (side1_q),
    .valid_o (vr),
    .root_o  (root),
    .side_o  (sider)
  );

  // Division: q = (2*mag*2^14 + L) / (2L), restoring, one bit per stage.
  logic [Q:1]   dv_q;
  logic [49:0]  num_q [3][Q+1];
  logic [33:0]  den_q [Q+1];
  logic [Q:0]   quo_q [3][Q+1];
  logic [32:0]  len_q [Q+1];
  cp_side_t     sd_q  [Q+1];

  logic [33:0] pmag [3];
  always_comb begin
    pmag[0] = 34'(sider.ax);
    pmag[1] = 34'(sider.ay);
    pmag[2] = 34'(sider.az);
  end

  for (genvar c = 0; c < 3; c++) begin : g_num
    always_comb begin
      num_q[c][0] = {1'b0, pmag[c], 15'd0} + 50'(root);
      quo_q[c][0] = '0;
    end
  end
  always_comb begin
    den_q[0] = {root, 1'b0};
    len_q[0] = root;
    sd_q[0]  = sider;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_q <= '0;
    end else begin
      dv_q <= {dv_q[Q-1:1], vr};
    end
  end

  // Quotient fits 15 bits (<= 16384); bits 15..0 resolved over Q stages.
  for (genvar s = 0; s < Q; s++) begin : g_div
    for (genvar c = 0; c < 3; c++) begin : g_comp
      logic [50:0] shd;
      logic        ge;
      always_comb begin
        shd = {den_q[s], 17'd0} >> (s + 2);
        ge  = {1'b0, num_q[c][s]} >= shd;
      end
      always_ff @(posedge clk_i) begin
        num_q[c][s+1] <= ge ? 50'({1'b0, num_q[c][s]} - shd) : num_q[c][s];
        quo_q[c][s+1] <= {quo_q[c][s][Q-1:0], ge};
      end
    end
    always_ff @(posedge clk_i) begin
      den_q[s+1] <= den_q[s];
      len_q[s+1] <= len_q[s];
      sd_q[s+1]  <= sd_q[s];
    end
  end

  // Output register.
  logic    done_q;
  cp_out_t out_q, out_d;
  logic [15:0] uq [3];
  logic        zl;
  always_comb begin
    zl = (len_q[Q] == '0);
    for (int c = 0; c < 3; c++) begin
      uq[c] = sd_q[Q].neg[2-c] ? 16'(-quo_q[c][Q][15:0]) : quo_q[c][Q][15:0];
      if (zl) uq[c] = '0;
    end
    out_d.mid_x = sd_q[Q].mid_x;
    out_d.mid_y = sd_q[Q].mid_y;
    out_d.mid_z = sd_q[Q].mid_z;
    out_d.unit_x = uq[0];
    out_d.unit_y = uq[1];
    out_d.unit_z = uq[2];
    out_d.signed_gap = sd_q[Q].is_outside ? 36'(len_q[Q]) : 36'(-36'(len_q[Q]));
    out_d.penetration = 36'(sd_q[Q].msum) - 36'(len_q[Q]);
    out_d.index_a_out = sd_q[Q].particle_a;
    out_d.index_b_out = sd_q[Q].particle_b;
    out_d.friction_out = sd_q[Q].friction_in;
    out_d.degenerate = zl;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= dv_q[Q];
    end
  end
  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign done_o = done_q;
  assign out_o  = out_q;

  `CP_ASSERT_IMP(a_never_busy, clk_i, rst_ni, 1'b1, !busy)
  `CP_ASSERT_NEXT(a_done_follows, clk_i, rst_ni, dv_q[Q], done_o)
  `CP_ASSERT_IMP(a_degen_zero, clk_i, rst_ni, done_o && out_o.degenerate,
                 out_o.unit_x == 16'sd0 && out_o.signed_gap == 36'sd0)
endmodule
`default_nettype wire
